// ===== rtl/core/csnap_pkg.sv =====
// shared types and constants for the clock snapshot translator
package csnap_pkg;

   // default sizing
   localparam int NUM_DOMAINS_DEF = 8;
   localparam int TABLE_DEPTH_DEF = 64;

   // field widths fixed by the interface
   localparam int TIME_W = 64;
   localparam int DOM_FIELD_W = 3;

   // item kinds
   localparam logic KIND_SYNC    = 1'b0;
   localparam logic KIND_CONVERT = 1'b1;

   // result status codes
   typedef enum logic [2:0] {
      ST_STORED     = 3'd0,
      ST_TRACE_BACK = 3'd1,
      ST_MONO_BACK  = 3'd2,
      ST_CONVERTED  = 3'd3,
      ST_EMPTY      = 3'd4,
      ST_FULL       = 3'd5
   } status_type;

   // input item
   typedef struct packed {
      logic                     kind;
      logic [DOM_FIELD_W-1:0]   domain;
      logic signed [TIME_W-1:0] clock_time;
      logic signed [TIME_W-1:0] trace_time;
   } req_type;

   // result item
   typedef struct packed {
      status_type               status;
      logic signed [TIME_W-1:0] converted_time;
   } rsp_type;

endpackage

// ===== rtl/core/csnap_mem.sv =====
// single-port snapshot store with registered read data
module csnap_mem #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] addr,
   input  logic              rd_en,
   input  logic              wr_en,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/csnap_ctrl.sv =====
// sequencer: entry counts, binary search, append and conversion arithmetic
module csnap_ctrl #(
   parameter int NUM_DOMAINS = csnap_pkg::NUM_DOMAINS_DEF,
   parameter int TABLE_DEPTH = csnap_pkg::TABLE_DEPTH_DEF,
   parameter int ADDR_W      = $clog2(NUM_DOMAINS * TABLE_DEPTH)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  csnap_pkg::req_type                     req_data,
   input  logic [csnap_pkg::DOM_FIELD_W-1:0]      mono_domain,
   output logic                                   rsp_valid,
   output csnap_pkg::rsp_type                     rsp_data,
   output logic [ADDR_W-1:0]                      mem_addr,
   output logic                                   mem_rd_en,
   output logic                                   mem_wr_en,
   output logic [csnap_pkg::TIME_W-1:0]           mem_wclock,
   output logic [csnap_pkg::TIME_W-1:0]           mem_wtrace,
   input  logic [csnap_pkg::TIME_W-1:0]           clk_rdata,
   input  logic [csnap_pkg::TIME_W-1:0]           trc_rdata
);
   import csnap_pkg::*;

   localparam int DOM_W = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOOK   = 6'b000010,
      S_CHECK  = 6'b000100,
      S_SEARCH = 6'b001000,
      S_DIFF   = 6'b010000,
      S_SUM    = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  count_ff [NUM_DOMAINS];
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]  mid_ff, mid_in;
   logic [TIME_W-1:0] diff_ff, diff_in;
   logic [TIME_W-1:0] trace_ff, trace_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [DOM_W-1:0]  dom_idx;
   logic              dom_ok;
   logic [CNT_W-1:0]  cnt;
   logic [CNT_W-1:0]  last_idx;
   logic              is_mono;
   logic [ADDR_W-1:0] base;
   logic [IDX_W-1:0]  mem_idx;
   logic              cnt_we;
   logic [CNT_W-1:0]  cnt_wval;
   logic              go_right;
   logic [CNT_W-1:0]  lo_n, hi_n, mid_n, sel;
   logic              search_more;
   logic              trace_back;
   logic              clock_back;

   // table selection for the held item
   assign dom_idx  = DOM_W'(req_ff.domain);
   assign dom_ok   = {{(32 - DOM_FIELD_W){1'b0}}, req_ff.domain} < 32'(NUM_DOMAINS);
   assign cnt      = dom_ok ? count_ff[dom_idx] : '0;
   assign last_idx = cnt - CNT_W'(1);
   assign is_mono  = (req_ff.domain == mono_domain);
   assign base     = ADDR_W'(ADDR_W'(dom_idx) * ADDR_W'(TABLE_DEPTH));
   assign mem_addr = ADDR_W'(base + ADDR_W'(mem_idx));

   // checks against the last stored pair
   assign trace_back = (req_ff.trace_time <= $signed(trc_rdata));
   assign clock_back = (req_ff.clock_time <= $signed(clk_rdata));

   // one search step: sync counts pairs below the key, convert pairs at or below
   always_comb begin
      if (req_ff.kind == KIND_SYNC) begin
         go_right = ($signed(clk_rdata) < req_ff.clock_time);
      end else begin
         go_right = ($signed(clk_rdata) <= req_ff.clock_time);
      end
      lo_n        = go_right ? CNT_W'(mid_ff + CNT_W'(1)) : lo_ff;
      hi_n        = go_right ? hi_ff : mid_ff;
      mid_n       = CNT_W'(lo_n + ((hi_n - lo_n) >> 1));
      search_more = (lo_n < hi_n);
      sel         = (lo_n != '0) ? CNT_W'(lo_n - CNT_W'(1)) : '0;
   end

   assign mem_wclock = req_ff.clock_time;
   assign mem_wtrace = req_ff.trace_time;

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      diff_in      = diff_ff;
      trace_in     = trace_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_idx      = '0;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      cnt_we       = 1'b0;
      cnt_wval     = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_LOOK;
            end
         end

         S_LOOK: begin
            if (!dom_ok) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: (req_ff.kind == KIND_SYNC) ? ST_FULL : ST_EMPTY,
                                converted_time: '0};
               state_in     = S_IDLE;
            end else if (req_ff.kind == KIND_SYNC) begin
               if (cnt == '0) begin
                  // first pair of an empty table
                  mem_wr_en    = 1'b1;
                  cnt_we       = 1'b1;
                  cnt_wval     = CNT_W'(1);
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_STORED, converted_time: '0};
                  state_in     = S_IDLE;
               end else begin
                  mem_idx   = last_idx[IDX_W-1:0];
                  mem_rd_en = 1'b1;
                  state_in  = S_CHECK;
               end
            end else begin
               if (cnt == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_EMPTY, converted_time: '0};
                  state_in     = S_IDLE;
               end else begin
                  lo_in     = '0;
                  hi_in     = cnt;
                  mid_in    = cnt >> 1;
                  mem_idx   = IDX_W'(cnt >> 1);
                  mem_rd_en = 1'b1;
                  state_in  = S_SEARCH;
               end
            end
         end

         S_CHECK: begin
            if (trace_back) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_TRACE_BACK, converted_time: '0};
               state_in     = S_IDLE;
            end else if (clock_back) begin
               if (is_mono) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_MONO_BACK, converted_time: '0};
                  state_in     = S_IDLE;
               end else begin
                  // find how many pairs survive the rollback
                  lo_in     = '0;
                  hi_in     = cnt;
                  mid_in    = cnt >> 1;
                  mem_idx   = IDX_W'(cnt >> 1);
                  mem_rd_en = 1'b1;
                  state_in  = S_SEARCH;
               end
            end else if (cnt >= CNT_W'(TABLE_DEPTH)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_FULL, converted_time: '0};
               state_in     = S_IDLE;
            end else begin
               mem_idx      = cnt[IDX_W-1:0];
               mem_wr_en    = 1'b1;
               cnt_we       = 1'b1;
               cnt_wval     = CNT_W'(cnt + CNT_W'(1));
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_STORED, converted_time: '0};
               state_in     = S_IDLE;
            end
         end

         S_SEARCH: begin
            lo_in  = lo_n;
            hi_in  = hi_n;
            mid_in = mid_n;
            if (search_more) begin
               mem_idx   = mid_n[IDX_W-1:0];
               mem_rd_en = 1'b1;
            end else if (req_ff.kind == KIND_SYNC) begin
               // drop the tail and append in its place
               mem_idx      = lo_n[IDX_W-1:0];
               mem_wr_en    = 1'b1;
               cnt_we       = 1'b1;
               cnt_wval     = CNT_W'(lo_n + CNT_W'(1));
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_STORED, converted_time: '0};
               state_in     = S_IDLE;
            end else begin
               mem_idx   = sel[IDX_W-1:0];
               mem_rd_en = 1'b1;
               state_in  = S_DIFF;
            end
         end

         S_DIFF: begin
            diff_in  = req_ff.clock_time - clk_rdata;
            trace_in = trc_rdata;
            state_in = S_SUM;
         end

         S_SUM: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ST_CONVERTED, converted_time: trace_ff + diff_ff};
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // per-domain fill counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DOMAINS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (cnt_we) begin
         count_ff[dom_idx] <= cnt_wval;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      diff_ff  <= diff_in;
      trace_ff <= trace_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/clock_snapshot_translator.sv =====
// clock snapshot translator top level: config register, sequencer and pair stores
// out-of-range domain, empty convert and first sync of an empty table answer from the lookup;
// other syncs check the last pair and search only when clock time falls back; convert
// searches, reads the chosen pair, then sums; at most ceil(log2(count+1)) search steps
// one transfer at a time, busy through the sequential search in the pair memory;
// busy drops as the strobe rises, so the next transfer can be taken with the result
// reset clears the fill counts and the monotonic domain; pair memory is not cleared
module clock_snapshot_translator #(
   parameter int NUM_DOMAINS = csnap_pkg::NUM_DOMAINS_DEF,
   parameter int TABLE_DEPTH = csnap_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  csnap_pkg::req_type                req_data,
   output logic                              rsp_valid,
   output csnap_pkg::rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [csnap_pkg::DOM_FIELD_W-1:0] csr_wdata
);
   import csnap_pkg::*;

   localparam int MEM_DEPTH = NUM_DOMAINS * TABLE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   logic [DOM_FIELD_W-1:0] mono_ff;
   logic [ADDR_W-1:0]      mem_addr;
   logic                   mem_rd_en;
   logic                   mem_wr_en;
   logic [TIME_W-1:0]      mem_wclock;
   logic [TIME_W-1:0]      mem_wtrace;
   logic [TIME_W-1:0]      clk_rdata;
   logic [TIME_W-1:0]      trc_rdata;

   // monotonic domain register
   always_ff @(posedge clock) begin
      if (reset) begin
         mono_ff <= '0;
      end else if (csr_we) begin
         mono_ff <= csr_wdata;
      end
   end

   // sequencer
   csnap_ctrl #(
      .NUM_DOMAINS (NUM_DOMAINS),
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .mono_domain (mono_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .mem_addr    (mem_addr),
      .mem_rd_en   (mem_rd_en),
      .mem_wr_en   (mem_wr_en),
      .mem_wclock  (mem_wclock),
      .mem_wtrace  (mem_wtrace),
      .clk_rdata   (clk_rdata),
      .trc_rdata   (trc_rdata)
   );

   // clock time store
   csnap_mem #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (TIME_W)
   ) u_clock_mem (
      .clock (clock),
      .addr  (mem_addr),
      .rd_en (mem_rd_en),
      .wr_en (mem_wr_en),
      .wdata (mem_wclock),
      .rdata (clk_rdata)
   );

   // trace time store
   csnap_mem #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (TIME_W)
   ) u_trace_mem (
      .clock (clock),
      .addr  (mem_addr),
      .rd_en (mem_rd_en),
      .wr_en (mem_wr_en),
      .wdata (mem_wtrace),
      .rdata (trc_rdata)
   );

endmodule

// ===== bench/clock_snapshot_translator_tb.sv =====
// self-checking testbench for the clock snapshot translator
`timescale 1ns / 100ps

module clock_snapshot_translator_tb;
   import csnap_pkg::*;

   localparam int NDOM  = NUM_DOMAINS_DEF;
   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam logic signed [TIME_W-1:0] T_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [TIME_W-1:0] T_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam int RANDOM_PHASES    = 6;
   localparam int ITEMS_PER_PHASE  = 175;
   localparam int FILL_ITEMS       = 70;
   localparam int SETTLE_CYCLES    = 16;
   localparam int PHASE_MONO [RANDOM_PHASES] = '{7, 3, 0, 5, 7, 1};
   localparam int PHASE_HOT  [RANDOM_PHASES] = '{7, 4, 6, 2, 0, 3};
   localparam bit PHASE_FILL [RANDOM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam int PHASE_IDLE [3] = '{0, 46, 29};

   // one directed row: stimulus plus an optional hand-written expectation
   typedef struct packed {
      logic                     kind;
      logic [DOM_FIELD_W-1:0]   domain;
      logic signed [TIME_W-1:0] clock_time;
      logic signed [TIME_W-1:0] trace_time;
      bit                       typed;
      status_type               status;
      logic signed [TIME_W-1:0] converted_time;
   } dir_row_type;

   localparam int DIR_ROWS = 24;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // empty domains, lowest and highest index
      '{KIND_CONVERT, 3'd0, 64'sd0, T_MAX, 1'b1, ST_EMPTY, 64'sd0},
      '{KIND_CONVERT, 3'd7, T_MAX, T_MIN, 1'b1, ST_EMPTY, 64'sd0},
      // extremes of both times
      '{KIND_SYNC, 3'd1, T_MIN, T_MIN, 1'b1, ST_STORED, 64'sd0},
      '{KIND_CONVERT, 3'd1, T_MAX, -64'sd1, 1'b0, ST_STORED, 64'sd0},
      '{KIND_SYNC, 3'd1, 64'sd100, T_MIN, 1'b1, ST_TRACE_BACK, 64'sd0},
      '{KIND_SYNC, 3'd1, 64'sd100, 64'sd0, 1'b1, ST_STORED, 64'sd0},
      '{KIND_SYNC, 3'd1, T_MAX, 64'sd1000, 1'b1, ST_STORED, 64'sd0},
      '{KIND_CONVERT, 3'd1, 64'sd50, 64'sd0, 1'b0, ST_STORED, 64'sd0},
      '{KIND_CONVERT, 3'd1, T_MIN, 64'sd0, 1'b0, ST_STORED, 64'sd0},
      // trace equal to the last one
      '{KIND_SYNC, 3'd1, 64'sd100, 64'sd1000, 1'b1, ST_TRACE_BACK, 64'sd0},
      // monotonic domain refuses equal and falling clock
      '{KIND_SYNC, 3'd0, 64'sd10, 64'sd10, 1'b1, ST_STORED, 64'sd0},
      '{KIND_SYNC, 3'd0, 64'sd10, 64'sd20, 1'b1, ST_MONO_BACK, 64'sd0},
      '{KIND_SYNC, 3'd0, 64'sd5, 64'sd30, 1'b1, ST_MONO_BACK, 64'sd0},
      // falling clock elsewhere drops the tail, then drops everything
      '{KIND_SYNC, 3'd1, 64'sd50, 64'sd2000, 1'b1, ST_STORED, 64'sd0},
      '{KIND_CONVERT, 3'd1, 64'sd60, 64'sd0, 1'b0, ST_STORED, 64'sd0},
      '{KIND_SYNC, 3'd1, T_MIN, T_MAX, 1'b1, ST_STORED, 64'sd0},
      '{KIND_CONVERT, 3'd1, 64'sd0, 64'sd0, 1'b0, ST_STORED, 64'sd0},
      // negative times, query below, between and above the pairs
      '{KIND_SYNC, 3'd2, -64'sd5, -64'sd1000, 1'b1, ST_STORED, 64'sd0},
      '{KIND_SYNC, 3'd2, 64'sd20, -64'sd900, 1'b1, ST_STORED, 64'sd0},
      '{KIND_CONVERT, 3'd2, -64'sd100, 64'sd0, 1'b0, ST_STORED, 64'sd0},
      '{KIND_CONVERT, 3'd2, 64'sd0, 64'sd0, 1'b0, ST_STORED, 64'sd0},
      '{KIND_CONVERT, 3'd2, 64'sd1000, 64'sd0, 1'b0, ST_STORED, 64'sd0},
      '{KIND_SYNC, 3'd7, 64'sd0, 64'sd0, 1'b1, ST_STORED, 64'sd0},
      '{KIND_CONVERT, 3'd7, -64'sd1, 64'sd0, 1'b0, ST_STORED, 64'sd0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   req_type                req_data = '0;
   logic                   csr_we = 1'b0;
   logic [DOM_FIELD_W-1:0] csr_wdata = '0;
   logic                   busy;
   logic                   rsp_valid;
   rsp_type                rsp_data;

   // shadow of the snapshot tables and the monotonic domain
   logic signed [TIME_W-1:0] pair_clock [NDOM][DEPTH];
   logic signed [TIME_W-1:0] pair_trace [NDOM][DEPTH];
   int                       pair_count [NDOM];
   int                       mono_dom;

   rsp_type pending_results [$];
   rsp_type head_result;
   int      mismatch_count = 0;

   clock_snapshot_translator #(
      .NUM_DOMAINS(NDOM),
      .TABLE_DEPTH(DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      #600000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // expected translation of one item, updating the shadow tables
   task automatic predict_translation(input req_type it, output rsp_type r);
      int d;
      int n;
      int sel;
      logic signed [TIME_W-1:0] clk;
      logic signed [TIME_W-1:0] trc;
      d = int'(it.domain);
      clk = it.clock_time;
      trc = it.trace_time;
      r = '0;
      if (d >= NDOM) begin
         r.status = (it.kind == KIND_CONVERT) ? ST_EMPTY : ST_FULL;
      end else if (it.kind == KIND_SYNC) begin
         n = pair_count[d];
         if (n > 0 && trc <= pair_trace[d][n-1]) begin
            r.status = ST_TRACE_BACK;
         end else if (n > 0 && clk <= pair_clock[d][n-1] && d == mono_dom) begin
            r.status = ST_MONO_BACK;
         end else begin
            // a falling clock trims every pair at or above it
            while (n > 0 && clk <= pair_clock[d][n-1])
               n--;
            pair_count[d] = n;
            if (n >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               pair_clock[d][n] = clk;
               pair_trace[d][n] = trc;
               pair_count[d] = n + 1;
               r.status = ST_STORED;
            end
         end
      end else begin
         n = pair_count[d];
         if (n == 0) begin
            r.status = ST_EMPTY;
         end else begin
            // last pair at or below the query, else the first pair
            sel = 0;
            for (int i = 0; i < n; i++)
               if (pair_clock[d][i] <= clk)
                  sel = i;
            r.status = ST_CONVERTED;
            r.converted_time = pair_trace[d][sel] + (clk - pair_clock[d][sel]);
         end
      end
   endtask

   // drive one item until the block takes it, then queue its expectation
   task automatic transfer_item(input req_type it, input bit typed, input status_type st,
                                input logic signed [TIME_W-1:0] conv);
      rsp_type predicted;
      start <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      predict_translation(it, predicted);
      if (typed) begin
         predicted.status = st;
         predicted.converted_time = conv;
      end
      pending_results.push_back(predicted);
   endtask

   task automatic idle_gap(input int pct);
      if ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // register write once every transfer has drained
   task automatic write_monotonic(input int value);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value[DOM_FIELD_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      mono_dom = value;
   endtask

   // mostly well-formed syncs and queries near the stored pairs, some noise
   function automatic req_type make_random_item(input int hot, input bit fill);
      req_type it;
      int d;
      int n;
      int k;
      int pick;
      int sub;
      logic signed [TIME_W-1:0] last_c;
      logic signed [TIME_W-1:0] last_t;
      logic signed [TIME_W-1:0] clk;
      logic signed [TIME_W-1:0] trc;
      it = '0;
      d = (fill || $urandom_range(0, 99) < 45) ? hot : $urandom_range(0, NDOM - 1);
      n = pair_count[d];
      if (n > 0) begin
         last_c = pair_clock[d][n-1];
         last_t = pair_trace[d][n-1];
      end else begin
         last_c = $signed({$urandom, $urandom}) >>> 2;
         last_t = $signed({$urandom, $urandom}) >>> 2;
      end
      pick = fill ? 0 : $urandom_range(0, 99);
      if (pick < 55) begin
         it.kind = KIND_SYNC;
         clk = last_c + $urandom_range(1, 2000);
         trc = last_t + $urandom_range(1, 2000);
         sub = fill ? 0 : $urandom_range(0, 99);
         if (sub >= 78 && sub < 86) begin
            trc = last_t - $urandom_range(0, 40);
         end else if (sub >= 86 && sub < 94 && n > 0) begin
            clk = pair_clock[d][$urandom_range(0, n - 1)] - $urandom_range(0, 3);
         end else if (sub >= 94) begin
            clk = {$urandom, $urandom};
            trc = {$urandom, $urandom};
         end
      end else begin
         it.kind = KIND_CONVERT;
         trc = {$urandom, $urandom};
         sub = $urandom_range(0, 99);
         if (n == 0 || sub >= 90) begin
            clk = {$urandom, $urandom};
         end else begin
            k = $urandom_range(0, n - 1);
            if (sub < 25)
               clk = pair_clock[d][k];
            else if (sub < 55)
               clk = pair_clock[d][k] + $urandom_range(0, 6) - 3;
            else if (sub < 70)
               clk = pair_clock[d][0] - $urandom_range(1, 5000);
            else
               clk = pair_clock[d][n-1] + $urandom_range(1, 100000);
         end
      end
      it.domain = d[DOM_FIELD_W-1:0];
      it.clock_time = clk;
      it.trace_time = trc;
      return it;
   endfunction

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no transfer pending");
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_data.status !== head_result.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_data.status, head_result.status));
            if (rsp_data.converted_time !== head_result.converted_time)
               report_mismatch($sformatf("converted_time %0h, expected %0h",
                                         rsp_data.converted_time,
                                         head_result.converted_time));
         end
      end
   end

   // stimulus: directed table, then random phases with register changes
   initial begin
      req_type it;
      for (int i = 0; i < NDOM; i++)
         pair_count[i] = 0;
      mono_dom = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         it.kind = DIR_TABLE[i].kind;
         it.domain = DIR_TABLE[i].domain;
         it.clock_time = DIR_TABLE[i].clock_time;
         it.trace_time = DIR_TABLE[i].trace_time;
         transfer_item(it, DIR_TABLE[i].typed, DIR_TABLE[i].status,
                       DIR_TABLE[i].converted_time);
      end
      start <= 1'b0;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_monotonic(PHASE_MONO[p]);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            idle_gap(PHASE_IDLE[p % 3]);
            it = make_random_item(PHASE_HOT[p], PHASE_FILL[p] && i < FILL_ITEMS);
            transfer_item(it, 1'b0, ST_STORED, '0);
         end
         start <= 1'b0;
      end

      // drain, then allow for any stray late result
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== clock_snapshot_translator.f =====
rtl/core/csnap_pkg.sv
rtl/core/csnap_mem.sv
rtl/core/csnap_ctrl.sv
rtl/core/clock_snapshot_translator.sv
bench/clock_snapshot_translator_tb.sv
